>>> rtl/core/sdfe_pkg.sv
package sdfe_pkg;

    // Field widths fixed by the item formats.
    localparam int MODE_W      = 1;
    localparam int TABLE_IDX_W = 6;
    localparam int ID_W        = 24;
    localparam int VALUE_W     = 64;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 7;

    // Default size of the used id table.
    localparam int MAX_USED_DEF = 64;

    // Depth of the command queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_LOAD    = 1'b0;
    localparam logic [MODE_W-1:0] MODE_ELEMENT = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [TABLE_IDX_W-1:0] table_index;
        logic [ID_W-1:0]        feature_id;
        logic [VALUE_W-1:0]     feature_value;
        logic                   last_element;
    } sdfe_in_t;

    typedef struct packed {
        logic [POS_W-1:0]   dense_position;
        logic [VALUE_W-1:0] dense_value;
        logic               dense_last;
    } sdfe_out_t;

    // Classified command handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_SKIP,
        CMD_LOAD,
        CMD_ELEM
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [TABLE_IDX_W-1:0] slot;
        logic [ID_W-1:0]        id;
        logic [VALUE_W-1:0]     value;
        logic                   last;
    } sdfe_cmd_t;

    // Back-end walker states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_PAD
    } back_state_t;

endpackage

>>> rtl/core/sparse_to_dense_feature_expander_core.sv
// Path: a sparse element passes the front's command register, a queue slot and the walker's
// held element register before its first dense result is written to the output register.
// The walker gives at most one dense result per cycle and takes no new command while busy;
// an element is dispatched and then walks the table, with an extra step when its walk does
// not end on a matching entry, and a last element also pads and rewinds. A table load is
// only dispatched. Output stalls hold the walker. Reset clears the cursor, the queue, the
// output valid flag and used_count; table entries are undefined until loaded.
module sparse_to_dense_feature_expander_core #(
    parameter int MAX_USED = sdfe_pkg::MAX_USED_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sdfe_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  sdfe_pkg::sdfe_in_t             item,
    output logic                           dense_valid,
    input  logic                           dense_ready,
    output sdfe_pkg::sdfe_out_t            dense
);
    import sdfe_pkg::*;

    localparam int CNT_W = $clog2(MAX_USED + 1);

    logic [COUNT_W-1:0] used_count_reg;
    logic [CNT_W-1:0]   valid_count;
    logic               f_valid;
    logic               f_ready;
    sdfe_cmd_t          f_cmd;
    logic               q_valid;
    logic               q_ready;
    sdfe_cmd_t          q_cmd;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            used_count_reg <= cfg_data;
        end
    end

    // A count above the table size acts as the table size.
    assign valid_count = (32'(used_count_reg) > MAX_USED) ? CNT_W'(MAX_USED)
                                                          : CNT_W'(used_count_reg);

    sdfe_front #(
        .MAX_USED (MAX_USED)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (f_valid),
        .cmd_ready  (f_ready),
        .cmd        (f_cmd)
    );

    sdfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    sdfe_back #(
        .MAX_USED (MAX_USED),
        .CNT_W    (CNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_count (valid_count),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd         (q_cmd),
        .dense_valid (dense_valid),
        .dense_ready (dense_ready),
        .dense       (dense)
    );

endmodule

>>> rtl/core/sdfe_front.sv
module sdfe_front #(
    parameter int MAX_USED = sdfe_pkg::MAX_USED_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  sdfe_pkg::sdfe_in_t item,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output sdfe_pkg::sdfe_cmd_t cmd
);
    import sdfe_pkg::*;

    logic      cmd_valid_reg;
    sdfe_cmd_t cmd_reg;
    sdfe_cmd_t cmd_next;
    logic      slot_in_range;

    // The stage takes a new transaction whenever its register is empty or drains.
    assign item_ready = !cmd_valid_reg || cmd_ready;
    assign cmd_valid  = cmd_valid_reg;
    assign cmd        = cmd_reg;

    // Loads aimed past the table end are turned into no-ops.
    assign slot_in_range = 32'(item.table_index) < MAX_USED;

    // Classify the incoming transaction.
    always_comb
    begin
        cmd_next.slot  = item.table_index;
        cmd_next.id    = item.feature_id;
        cmd_next.value = item.feature_value;
        cmd_next.last  = item.last_element;
        if (item.mode == MODE_ELEMENT)
        begin
            cmd_next.kind = CMD_ELEM;
        end
        else if (slot_in_range)
        begin
            cmd_next.kind = CMD_LOAD;
        end
        else
        begin
            cmd_next.kind = CMD_SKIP;
        end
    end

    // Valid flag of the command register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            cmd_valid_reg <= item_valid;
        end
    end

    // Command payload.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> rtl/core/sdfe_queue.sv
module sdfe_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  sdfe_pkg::sdfe_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sdfe_pkg::sdfe_cmd_t pop_cmd
);
    import sdfe_pkg::*;

    sdfe_cmd_t          slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != (Q_PTR_W+1)'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (Q_PTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (Q_PTR_W+1)'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/sdfe_back.sv
module sdfe_back #(
    parameter int MAX_USED = sdfe_pkg::MAX_USED_DEF,
    parameter int CNT_W    = $clog2(MAX_USED + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNT_W-1:0]    valid_count,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  sdfe_pkg::sdfe_cmd_t cmd,
    output logic                dense_valid,
    input  logic                dense_ready,
    output sdfe_pkg::sdfe_out_t dense
);
    import sdfe_pkg::*;

    localparam int IDX_W = (MAX_USED > 1) ? $clog2(MAX_USED) : 1;

    logic [ID_W-1:0]    table_mem [MAX_USED];
    logic [ID_W-1:0]    entry_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [CNT_W-1:0]   cursor_reg;
    logic [CNT_W-1:0]   cursor_next;
    logic [ID_W-1:0]    elem_id_reg;
    logic [VALUE_W-1:0] elem_value_reg;
    logic               elem_last_reg;

    logic               out_valid_reg;
    sdfe_out_t          out_reg;
    logic               out_free;
    logic               cur_lt_n;
    logic               id_gt;
    logic               id_eq;
    logic               final_pos;
    logic               take_cmd;
    logic               emit;
    logic [VALUE_W-1:0] emit_value;

    // Compare the held element against the table entry under the cursor.
    assign cur_lt_n  = cursor_reg < valid_count;
    assign id_gt     = elem_id_reg > entry_reg;
    assign id_eq     = elem_id_reg == entry_reg;
    assign final_pos = ((CNT_W+1)'(cursor_reg) + (CNT_W+1)'(1)) >= (CNT_W+1)'(valid_count);
    assign out_free  = !out_valid_reg || dense_ready;

    assign take_cmd  = (state_reg == BK_IDLE) && cmd_valid;
    assign cmd_ready = state_reg == BK_IDLE;

    // Next-state logic of the walker.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (take_cmd && cmd.kind == CMD_ELEM)
                begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (cur_lt_n && id_gt)
                begin
                    state_next = BK_WALK;
                end
                else if (cur_lt_n && id_eq && !out_free)
                begin
                    state_next = BK_WALK;
                end
                else if (elem_last_reg)
                begin
                    state_next = BK_PAD;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_PAD:
            begin
                if (!cur_lt_n)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Output logic: result emission, cursor movement and table writes.
    always_comb
    begin
        emit        = 1'b0;
        emit_value  = '0;
        cursor_next = cursor_reg;
        wr_en       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                wr_en = take_cmd && cmd.kind == CMD_LOAD;
            end
            BK_WALK:
            begin
                if (cur_lt_n && (id_gt || id_eq) && out_free)
                begin
                    emit        = 1'b1;
                    emit_value  = id_gt ? '0 : elem_value_reg;
                    cursor_next = cursor_reg + CNT_W'(1);
                end
            end
            BK_PAD:
            begin
                if (!cur_lt_n)
                begin
                    cursor_next = '0;
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    cursor_next = cursor_reg + CNT_W'(1);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign wr_addr = cmd.slot[IDX_W-1:0];
    assign rd_addr = cursor_next[IDX_W-1:0];

    // Used id table; the entry under the next cursor is read every cycle,
    // with a same-cycle write passed straight through.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= cmd.id;
        end
        if (wr_en && wr_addr == rd_addr)
        begin
            entry_reg <= cmd.id;
        end
        else
        begin
            entry_reg <= table_mem[rd_addr];
        end
    end

    // Walker control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dense_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Held element and output payload.
    always_ff @(posedge clk)
    begin
        if (take_cmd && cmd.kind == CMD_ELEM)
        begin
            elem_id_reg    <= cmd.id;
            elem_value_reg <= cmd.value;
            elem_last_reg  <= cmd.last;
        end
        if (emit)
        begin
            out_reg.dense_position <= POS_W'(cursor_reg);
            out_reg.dense_value    <= emit_value;
            out_reg.dense_last     <= elem_last_reg && final_pos;
        end
    end

    assign dense_valid = out_valid_reg;
    assign dense       = out_reg;

endmodule

>>> tb/sdfe_checker.sv
module sdfe_checker #(
    parameter int MAX_USED = sdfe_pkg::MAX_USED_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [sdfe_pkg::COUNT_W-1:0] cfg_data,
    input  logic                         item_valid,
    input  logic                         item_ready,
    input  sdfe_pkg::sdfe_in_t           item,
    input  logic                         dense_valid,
    input  logic                         dense_ready,
    input  sdfe_pkg::sdfe_out_t          dense,
    output int                           errors,
    output int                           pending
);
    import sdfe_pkg::*;

    // Shadow copy of the used id table, the walk position and the count register.
    logic [ID_W-1:0]    id_image [MAX_USED] = '{default: '0};
    int                 walk_pos = 0;
    logic [COUNT_W-1:0] live_count = '0;

    // Dense results predicted but not yet seen, oldest first.
    sdfe_out_t          dense_due [$];

    function automatic void queue_dense(input int pos, input logic [VALUE_W-1:0] value);
        sdfe_out_t r;
        r.dense_position = pos[POS_W-1:0];
        r.dense_value    = value;
        r.dense_last     = 1'b0;
        dense_due = {dense_due, r};
    endfunction

    // Walk the table for one sparse element and queue the dense values it produces.
    function automatic void expand_element(input sdfe_in_t it);
        int        span;
        int        made;
        sdfe_out_t tail;
        span = (live_count > MAX_USED) ? MAX_USED : int'(live_count);
        made = 0;
        // Zeros for every used id that the element skips over.
        while (walk_pos < span && it.feature_id > id_image[walk_pos])
        begin
            queue_dense(walk_pos, '0);
            walk_pos++;
            made++;
        end
        // The element's own value when its id is in the table.
        if (walk_pos < span && it.feature_id == id_image[walk_pos])
        begin
            queue_dense(walk_pos, it.feature_value);
            walk_pos++;
            made++;
        end
        // The last element pads the instance, flags its final value and rewinds.
        if (it.last_element)
        begin
            while (walk_pos < span)
            begin
                queue_dense(walk_pos, '0);
                walk_pos++;
                made++;
            end
            if (made > 0)
            begin
                tail = dense_due.pop_back();
                tail.dense_last = 1'b1;
                dense_due = {dense_due, tail};
            end
            walk_pos = 0;
        end
    endfunction

    function automatic void check_dense(input sdfe_out_t got);
        sdfe_out_t want;
        if (dense_due.size() == 0)
        begin
            $error("unexpected dense transaction: position %0d value %h last %0b",
                   got.dense_position, got.dense_value, got.dense_last);
            errors++;
            return;
        end
        want = dense_due.pop_front();
        if (got.dense_position !== want.dense_position)
        begin
            $error("dense_position: expected %0d, got %0d",
                   want.dense_position, got.dense_position);
            errors++;
        end
        if (got.dense_value !== want.dense_value)
        begin
            $error("dense_value: expected %h, got %h", want.dense_value, got.dense_value);
            errors++;
        end
        if (got.dense_last !== want.dense_last)
        begin
            $error("dense_last: expected %0b, got %0b", want.dense_last, got.dense_last);
            errors++;
        end
    endfunction

    // Results are compared before the same edge's input is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_pos   = 0;
            live_count = '0;
            dense_due.delete();
            pending    = 0;
        end
        else
        begin
            if (dense_valid && dense_ready)
            begin
                check_dense(dense);
            end
            if (cfg_valid && cfg_ready)
            begin
                live_count = cfg_data;
            end
            if (item_valid && item_ready)
            begin
                if (item.mode == MODE_LOAD)
                begin
                    if (item.table_index < MAX_USED)
                    begin
                        id_image[item.table_index] = item.feature_id;
                    end
                end
                else
                begin
                    expand_element(item);
                end
            end
            pending = dense_due.size();
        end
    end

endmodule

>>> tb/testbench.sv
module testbench;
    import sdfe_pkg::*;

    localparam int TABLE_SLOTS       = MAX_USED_DEF;
    localparam int ID_MAX            = (1 << ID_W) - 1;
    localparam int SETTLE_CYCLES     = 24;
    localparam int STALL_LIMIT       = 1000;
    localparam int ELEMS_PER_SEGMENT = 8;
    localparam int COUNT_MAX         = (1 << COUNT_W) - 1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    sdfe_in_t           item = '0;
    logic               dense_valid;
    logic               dense_ready = 1'b0;
    sdfe_out_t          dense;

    int fail_count;
    int due_count;
    int send_idle = 9;
    int recv_idle = 45;
    int stall_cycles = 0;

    // What the stimulus has put into the table, used to pick element ids.
    logic [ID_W-1:0] table_img [TABLE_SLOTS];
    bit              loaded [TABLE_SLOTS];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sparse_to_dense_feature_expander_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .dense_valid (dense_valid),
        .dense_ready (dense_ready),
        .dense       (dense)
    );

    sdfe_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .dense_valid (dense_valid),
        .dense_ready (dense_ready),
        .dense       (dense),
        .errors      (fail_count),
        .pending     (due_count)
    );

    // The receiver stalls at random at the current rate.
    always @(posedge clk)
    begin
        dense_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Valid stays high from one transaction to the next unless the sender idles.
    task automatic push_item(input sdfe_in_t it);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic load_slot(input int slot, input logic [ID_W-1:0] id);
        sdfe_in_t it;
        it.mode          = MODE_LOAD;
        it.table_index   = slot[TABLE_IDX_W-1:0];
        it.feature_id    = id;
        it.feature_value = {$urandom, $urandom};
        it.last_element  = 1'($urandom_range(1));
        table_img[slot]  = id;
        loaded[slot]     = 1'b1;
        push_item(it);
    endtask

    task automatic push_element(input logic [ID_W-1:0] id, input logic [VALUE_W-1:0] value,
                                input bit last);
        sdfe_in_t it;
        it.mode          = MODE_ELEMENT;
        it.table_index   = TABLE_IDX_W'($urandom);
        it.feature_id    = id;
        it.feature_value = value;
        it.last_element  = last;
        push_item(it);
    endtask

    // Wait until the block is drained; set_count then writes the used count.
    task automatic drain();
        item_valid <= 1'b0;
        do @(negedge clk); while (due_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value[COUNT_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Ascending table with a step size that varies from table to table.
    task automatic load_sorted(input int n);
        int step_max;
        int cur;
        case ($urandom_range(2))
            0: step_max = 1;
            1: step_max = 8;
            default: step_max = 200000;
        endcase
        cur = $urandom_range(0, 50);
        for (int i = 0; i < n; i++)
        begin
            load_slot(i, cur[ID_W-1:0]);
            cur += $urandom_range(1, step_max);
        end
    endtask

    // One instance: mostly ascending ids that hit the table, with misses,
    // ids past the table end, out-of-order ids and stray table loads mixed in.
    task automatic send_instance(input int n, input int len);
        int p;
        int lo;
        int id;
        int r;
        int slot;
        p  = 0;
        lo = 0;
        for (int e = 0; e < len; e++)
        begin
            if ($urandom_range(99) < 8)
            begin
                slot = $urandom_range(0, TABLE_SLOTS - 1);
                load_slot(slot, loaded[slot] ? table_img[slot] : ID_W'($urandom));
            end
            r = $urandom_range(99);
            if (r < 60 && p < n)
            begin
                p = p + $urandom_range(0, 1);
                if (p >= n) p = n - 1;
                id = int'(table_img[p]);
                p++;
            end
            else if (r < 85)
            begin
                id = lo + $urandom_range(0, 2);
            end
            else if (r < 95)
            begin
                id = $urandom_range(lo, ID_MAX);
            end
            else
            begin
                id = $urandom_range(0, ID_MAX);
            end
            if (id > ID_MAX) id = ID_MAX;
            if (id > lo) lo = id;
            push_element(id[ID_W-1:0], {$urandom, $urandom}, e == len - 1);
        end
    endtask

    // Each segment picks a count setting and may load a new table, then sends instances.
    task automatic run_segment(input int k);
        int n;
        int sent;
        int len;
        case (k)
            0:
            begin
                n = $urandom_range(1, 16);
                set_count(n);
                load_sorted(n);
            end
            1:
            begin
                n = TABLE_SLOTS;
                set_count(n);
                load_sorted(n);
            end
            2:
            begin
                // Count above the table size acts as a full table.
                set_count(COUNT_MAX);
                n = TABLE_SLOTS;
            end
            3:
            begin
                set_count(0);
                n = 0;
            end
            4:
            begin
                set_count($urandom_range(TABLE_SLOTS + 1, COUNT_MAX - 1));
                n = TABLE_SLOTS;
            end
            default:
            begin
                // Small unsorted table.
                n = $urandom_range(1, 16);
                set_count(n);
                for (int i = 0; i < n; i++)
                begin
                    load_slot(i, ID_W'($urandom_range(0, 300)));
                end
            end
        endcase
        sent = 0;
        while (sent < ELEMS_PER_SEGMENT)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
            send_instance(n, len);
            sent += len;
        end
    endtask

    // Watchdog on cycles without any transaction.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (dense_valid && dense_ready) ||
                (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: elements give nothing, the last one flags nothing.
        push_element(24'h000010, {$urandom, $urandom}, 1'b0);
        push_element(24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

        // Small table with both id extremes.
        load_slot(0, 24'h000000);
        load_slot(1, 24'h000005);
        load_slot(2, 24'h000009);
        load_slot(3, 24'hFFFFFF);
        load_slot(TABLE_SLOTS - 1, 24'h000123);
        set_count(4);

        // Hit, miss with a skipped id, zero value, and a final hit at the top id.
        push_element(24'h000000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_element(24'h000007, {$urandom, $urandom}, 1'b0);
        push_element(24'h000009, 64'h0, 1'b0);
        push_element(24'hFFFFFF, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1);

        // A lone missing id, padded to the end of the table.
        push_element(24'h000003, {$urandom, $urandom}, 1'b1);

        // The top id twice, the second time past the table end, then a last element with nothing left.
        push_element(24'hFFFFFF, {$urandom, $urandom}, 1'b0);
        push_element(24'hFFFFFF, {$urandom, $urandom}, 1'b0);
        push_element(24'h000001, {$urandom, $urandom}, 1'b1);

        // Count lowered below the walk position in the middle of an instance.
        push_element(24'h000005, {$urandom, $urandom}, 1'b0);
        set_count(1);
        push_element(24'h000009, {$urandom, $urandom}, 1'b0);
        push_element(24'h00000C, {$urandom, $urandom}, 1'b1);

        // Unsorted table walked the same way.
        load_slot(1, 24'h000014);
        set_count(4);
        push_element(24'h000009, {$urandom, $urandom}, 1'b1);

        // Random part in three idling phases, two count settings each.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 9;
                    recv_idle = 45;
                end
                1:
                begin
                    send_idle = 45;
                    recv_idle = 9;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            run_segment(ph * 2);
            run_segment(ph * 2 + 1);
        end

        drain();
        if (fail_count == 0 && due_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
